### rtl/mps_pkg.sv
package mps_pkg;

   // Number of path positions in one pass; later items share the last position.
   localparam int MAX_PATHS = 16;
   localparam int POS_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

   // Width of the exclude_index and best_index fields.
   localparam int IDX_W = 4;

   // Positions and the exclude index are compared at the wider of the two widths.
   localparam int CMP_W = (POS_W > IDX_W) ? POS_W : IDX_W;

   localparam logic [POS_W-1:0] POS_FIRST = '0;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_PATHS - 1);

   // Stream data widths, padded to whole bytes.
   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 8;

   // Metrics of one path as the rank logic sees them. The free window and the
   // slow start flag are worked out before the path is registered.
   typedef struct packed {
      logic        usable;
      logic [7:0]  retransmits;
      logic [7:0]  retry_limit;
      logic [15:0] dups;
      logic [31:0] rto;
      logic        out_of_ss;
      logic [31:0] free_win;
   } path_type;

   // Free send window, cwnd + mtu - 1 - bytes_out, modulo 2^32.
   function automatic logic [31:0] free_window(
      input logic [31:0] cwnd,
      input logic [15:0] mtu,
      input logic [31:0] bytes_out
   );
      return cwnd + {16'h0000, mtu} - 32'd1 - bytes_out;
   endfunction

endpackage

### rtl/mps_rank.sv
module mps_rank (
   input  mps_pkg::path_type         best,
   input  logic [mps_pkg::POS_W-1:0] best_pos,
   input  mps_pkg::path_type         cand,
   input  logic [mps_pkg::POS_W-1:0] cand_pos,
   input  logic                      exclude_valid,
   input  logic [mps_pkg::IDX_W-1:0] exclude_index,
   output logic                      cand_wins
);

   logic [mps_pkg::CMP_W-1:0] best_pos_cmp;
   logic [mps_pkg::CMP_W-1:0] cand_pos_cmp;
   logic [mps_pkg::CMP_W-1:0] excl_cmp;
   logic [8:0]                best_excess;
   logic [8:0]                cand_excess;

   assign best_pos_cmp = mps_pkg::CMP_W'(best_pos);
   assign cand_pos_cmp = mps_pkg::CMP_W'(cand_pos);
   assign excl_cmp     = mps_pkg::CMP_W'(exclude_index);

   // Excess timeouts are compared cross-wise at nine bits so no sum wraps.
   assign best_excess = {1'b0, best.retransmits} + {1'b0, cand.retry_limit};
   assign cand_excess = {1'b0, cand.retransmits} + {1'b0, best.retry_limit};

   // Priority cascade: the first rule that separates the two paths decides.
   always_comb begin
      if (!best.usable && cand.usable) begin
         cand_wins = 1'b1;
      end else if (best.retransmits > best.retry_limit
                   && cand.retransmits <= cand.retry_limit) begin
         cand_wins = 1'b1;
      end else if (best.retransmits != 8'd0 && cand.retransmits == 8'd0) begin
         cand_wins = 1'b1;
      end else if (best.dups != 16'd0 && cand.dups == 16'd0) begin
         cand_wins = 1'b1;
      end else if (exclude_valid && best_pos_cmp == excl_cmp
                   && cand_pos_cmp != excl_cmp) begin
         cand_wins = 1'b1;
      end else if (best_excess > cand_excess) begin
         cand_wins = 1'b1;
      end else if (best.dups > cand.dups) begin
         cand_wins = 1'b1;
      end else if (best.rto > cand.rto) begin
         cand_wins = 1'b1;
      end else if (!best.out_of_ss && cand.out_of_ss) begin
         cand_wins = 1'b1;
      end else if (best.free_win < cand.free_win) begin
         cand_wins = 1'b1;
      end else begin
         cand_wins = 1'b0;
      end
   end

endmodule

### rtl/multihome_path_selector_unit.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/tready    | tdata: path metrics, tlast: end of pass
// rsp     | out       | rsp_tvalid/tready    | tdata: best_index
//
// One request per cycle is taken unless the input register is stalled. A request
// is registered, ranked against the registered best path in the next cycle, and
// the result of a pass is loaded into the rsp register when its last request
// leaves the input register. Reset clears the pass position and the valid flags;
// the best-path metrics are written by the first request of each pass. A stalled
// rsp channel holds back only a last request and those behind it; others flow.
module multihome_path_selector_unit (
   input  logic                           clock,
   input  logic                           reset,
   // usable[0], retransmits[8:1], retry_limit[16:9], dups[32:17], rto[64:33],
   // cwnd[96:65], ssthresh[128:97], mtu[144:129], bytes_out[176:145],
   // exclude_valid[177], exclude_index[181:178], zero[183:182]
   input  logic [mps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // best_index[3:0], zero[7:4]
   output logic [mps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready
);

   // Request decode into rank metrics.
   mps_pkg::path_type         req_path;
   logic                      req_accept;

   always_comb begin
      req_path.usable      = req_tdata[0];
      req_path.retransmits = req_tdata[8:1];
      req_path.retry_limit = req_tdata[16:9];
      req_path.dups        = req_tdata[32:17];
      req_path.rto         = req_tdata[64:33];
      req_path.out_of_ss   = req_tdata[96:65] > req_tdata[128:97];
      req_path.free_win    = mps_pkg::free_window(req_tdata[96:65], req_tdata[144:129],
                                                  req_tdata[176:145]);
   end

   assign req_accept = req_tvalid && req_tready;

   // Input register.
   logic                          stage_valid_ff;
   logic                          stage_valid_in;
   mps_pkg::path_type             stage_path_ff;
   logic                          stage_excl_valid_ff;
   logic [mps_pkg::IDX_W-1:0]     stage_excl_index_ff;
   logic                          stage_last_ff;
   logic                          stage_fire;

   // Best-path state and pass position.
   mps_pkg::path_type             best_path_ff;
   logic [mps_pkg::POS_W-1:0]     best_pos_ff;
   logic [mps_pkg::POS_W-1:0]     pos_ff;
   logic [mps_pkg::POS_W-1:0]     pos_in;
   logic                          cand_wins;
   logic                          take;
   logic [mps_pkg::POS_W-1:0]     best_pos_in;

   // Result register.
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [mps_pkg::IDX_W-1:0]     rsp_index_ff;

   // A request that ends a pass waits for room in the result register.
   assign stage_fire = stage_valid_ff && (!stage_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || stage_fire;

   always_comb begin
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_fire) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_path_ff       <= req_path;
         stage_excl_valid_ff <= req_tdata[177];
         stage_excl_index_ff <= req_tdata[181:178];
         stage_last_ff       <= req_tlast;
      end
   end

   // Rank the registered request against the running best.
   mps_rank u_rank (
      .best          (best_path_ff),
      .best_pos      (best_pos_ff),
      .cand          (stage_path_ff),
      .cand_pos      (pos_ff),
      .exclude_valid (stage_excl_valid_ff),
      .exclude_index (stage_excl_index_ff),
      .cand_wins     (cand_wins)
   );

   assign take        = (pos_ff == mps_pkg::POS_FIRST) || cand_wins;
   assign best_pos_in = take ? pos_ff : best_pos_ff;

   // Position advances and saturates; the last request starts a new pass.
   always_comb begin
      if (stage_last_ff) begin
         pos_in = mps_pkg::POS_FIRST;
      end else if (pos_ff < mps_pkg::POS_LAST) begin
         pos_in = pos_ff + 1'b1;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= mps_pkg::POS_FIRST;
      end else if (stage_fire) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire && take) begin
         best_path_ff <= stage_path_ff;
         best_pos_ff  <= pos_ff;
      end
   end

   // Result register loads the chosen position at the end of a pass.
   always_comb begin
      if (stage_fire && stage_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire && stage_last_ff) begin
         rsp_index_ff <= best_pos_in[mps_pkg::IDX_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mps_pkg::RSP_DATA_W'(rsp_index_ff);

   // A new result appears only after a request that ended a pass.
   a_rsp_after_last : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_valid_ff && stage_last_ff))
      else $error("result raised without a last request");

   // The request that ends a pass restarts the position count.
   a_pass_restart : assert property (@(posedge clock) disable iff (reset)
      (stage_fire && stage_last_ff) |=> pos_ff == mps_pkg::POS_FIRST)
      else $error("position not cleared after end of pass");

   // A pending result that is not taken blocks the next end of pass.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && stage_valid_ff && stage_last_ff) |-> !stage_fire)
      else $error("pending result overwritten");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // Run length and stimulus sizing.
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned RANDOM_ITEMS = 1676;
   localparam int unsigned PHASE_ITEMS = 340;
   localparam int unsigned HOLD_OFF_START = 200;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   // Idling behavior attached to each request.
   typedef enum logic [1:0] {
      PHASE_FREE,
      PHASE_SENDER_IDLE,
      PHASE_RECEIVER_STALL,
      PHASE_BOTH
   } idle_phase_type;

   // One path request as the driver queues it.
   typedef struct {
      bit             usable;
      bit [7:0]       retransmits;
      bit [7:0]       retrans_limit;
      bit [15:0]      dups;
      bit [31:0]      rto;
      bit [31:0]      cwnd;
      bit [31:0]      ssthresh;
      bit [15:0]      mtu;
      bit [31:0]      bytes_out;
      bit             exclude_valid;
      bit [3:0]       exclude_index;
      bit             last;
      idle_phase_type phase;
   } path_req_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic [mps_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [mps_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;

   path_req_type   path_queue[$];
   bit [3:0]       best_index_q[$];
   path_req_type   best_path;
   bit [3:0]       best_pos;
   bit [3:0]       pass_pos;
   idle_phase_type active_phase = PHASE_FREE;
   logic           hold_off = 1'b0;
   int unsigned    accepted_count = 0;
   int unsigned    error_count = 0;
   int unsigned    cycle_count = 0;

   multihome_path_selector_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Packs the metrics into the request data bus, first field lowest.
   function automatic logic [mps_pkg::REQ_DATA_W-1:0] pack_path(input path_req_type p);
      return {2'b00, p.exclude_index, p.exclude_valid, p.bytes_out, p.mtu, p.ssthresh,
              p.cwnd, p.rto, p.dups, p.retrans_limit, p.retransmits, p.usable};
   endfunction

   function automatic bit [31:0] spare_window(input path_req_type p);
      return p.cwnd + {16'h0000, p.mtu} - 32'd1 - p.bytes_out;
   endfunction

   // Ranking cascade: the first rule that fires decides in favor of the candidate.
   function automatic bit path_beats_best(input path_req_type cand, input bit [3:0] pos);
      bit [8:0] best_excess;
      bit [8:0] cand_excess;
      best_excess = {1'b0, best_path.retransmits} + {1'b0, cand.retrans_limit};
      cand_excess = {1'b0, cand.retransmits} + {1'b0, best_path.retrans_limit};
      if (!best_path.usable && cand.usable) return 1'b1;
      if (best_path.retransmits > best_path.retrans_limit &&
          cand.retransmits <= cand.retrans_limit) return 1'b1;
      if (best_path.retransmits != 8'd0 && cand.retransmits == 8'd0) return 1'b1;
      if (best_path.dups != 16'd0 && cand.dups == 16'd0) return 1'b1;
      if (cand.exclude_valid && best_pos == cand.exclude_index &&
          pos != cand.exclude_index) return 1'b1;
      if (best_excess > cand_excess) return 1'b1;
      if (best_path.dups > cand.dups) return 1'b1;
      if (best_path.rto > cand.rto) return 1'b1;
      if (best_path.cwnd <= best_path.ssthresh && cand.cwnd > cand.ssthresh) return 1'b1;
      if (spare_window(best_path) < spare_window(cand)) return 1'b1;
      return 1'b0;
   endfunction

   // Updates the running best for an accepted request; a last request yields a result.
   task automatic rank_path(input path_req_type p);
      if (pass_pos == 4'd0 || path_beats_best(p, pass_pos)) begin
         best_path = p;
         best_pos = pass_pos;
      end
      if (p.last) begin
         best_index_q.push_back(best_pos);
         pass_pos = 4'd0;
      end else if (pass_pos < 4'(mps_pkg::MAX_PATHS - 1)) begin
         pass_pos = pass_pos + 4'd1;
      end
   endtask

   function automatic int unsigned idle_percent(input idle_phase_type ph, input bit receiver);
      case (ph)
         PHASE_SENDER_IDLE:    return receiver ? 0 : 87;
         PHASE_RECEIVER_STALL: return receiver ? 87 : 0;
         PHASE_BOTH:           return 30;
         default:              return 0;
      endcase
   endfunction

   // Field values biased toward zero, small numbers and the top of the range.
   function automatic bit [31:0] pick_value(input int unsigned bits);
      bit [31:0] mask;
      bit [31:0] v;
      mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
      case ($urandom_range(0, 5))
         0:       v = 32'd0;
         1:       v = $urandom_range(0, 3);
         2:       v = 32'hFFFF_FFFF - $urandom_range(0, 2);
         default: v = $urandom;
      endcase
      return v & mask;
   endfunction

   function automatic path_req_type random_path();
      path_req_type p;
      p.usable = $urandom_range(0, 3) != 0;
      p.retransmits = pick_value(8);
      p.retrans_limit = pick_value(8);
      p.dups = pick_value(16);
      p.rto = pick_value(32);
      p.cwnd = pick_value(32);
      p.ssthresh = pick_value(32);
      p.mtu = pick_value(16);
      p.bytes_out = pick_value(32);
      p.exclude_valid = 1'b0;
      p.exclude_index = 4'd0;
      p.last = 1'b0;
      p.phase = PHASE_FREE;
      return p;
   endfunction

   // Changes one metric so that ties reach the deeper rules.
   function automatic path_req_type mutate_path(input path_req_type p);
      case ($urandom_range(0, 9))
         0: p.usable = ~p.usable;
         1: p.retransmits = pick_value(8);
         2: p.retrans_limit = pick_value(8);
         3: p.dups = pick_value(16);
         4: p.rto = p.rto + $urandom_range(0, 2) - 1;
         5: p.rto = pick_value(32);
         6: p.cwnd = pick_value(32);
         7: p.ssthresh = pick_value(32);
         8: p.mtu = pick_value(16);
         default: p.bytes_out = p.bytes_out + $urandom_range(0, 2) - 1;
      endcase
      return p;
   endfunction

   // A healthy path that ties with itself on every rule.
   function automatic path_req_type base_path();
      path_req_type p;
      p = random_path();
      p.usable = 1'b1;
      p.retransmits = 8'd0;
      p.retrans_limit = 8'd5;
      p.dups = 16'd0;
      p.rto = 32'd100;
      p.cwnd = 32'd1000;
      p.ssthresh = 32'd500;
      p.mtu = 16'd1500;
      p.bytes_out = 32'd0;
      return p;
   endfunction

   task automatic queue_pair(input path_req_type first_path, input path_req_type second_path);
      first_path.last = 1'b0;
      second_path.last = 1'b1;
      path_queue.push_back(first_path);
      path_queue.push_back(second_path);
   endtask

   // Directed passes: extremes, a tie, and each rule deciding a pair.
   task automatic queue_directed();
      path_req_type a;
      path_req_type b;
      a = '{1'b1, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'hF, 1'b1, PHASE_FREE};
      path_queue.push_back(a);
      a = '{1'b0, 8'h00, 8'h00, 16'h0000, 32'h0, 32'h0, 32'h0, 16'h0000, 32'h0,
            1'b0, 4'h0, 1'b1, PHASE_FREE};
      path_queue.push_back(a);
      a = base_path();
      queue_pair(a, a);
      // Usable route.
      a = base_path(); b = a; a.usable = 1'b0;
      queue_pair(a, b);
      // Within the retransmit limit.
      a = base_path(); b = a; a.retransmits = 8'd6; b.retransmits = 8'd1;
      queue_pair(a, b);
      // No timeouts.
      a = base_path(); b = a; a.retransmits = 8'd1;
      queue_pair(a, b);
      // No duplicates.
      a = base_path(); b = a; a.dups = 16'd3;
      queue_pair(a, b);
      // Excluded path.
      a = base_path(); b = a; b.exclude_valid = 1'b1; b.exclude_index = 4'd0;
      queue_pair(a, b);
      // Fewer excess timeouts.
      a = base_path(); b = a; a.retransmits = 8'd3; b.retransmits = 8'd2;
      queue_pair(a, b);
      // Fewer duplicates.
      a = base_path(); b = a; a.dups = 16'd5; b.dups = 16'd2;
      queue_pair(a, b);
      // Lower RTO.
      a = base_path(); b = a; a.rto = 32'd200;
      queue_pair(a, b);
      // Out of slow start.
      a = base_path(); b = a; a.cwnd = 32'd500;
      queue_pair(a, b);
      // Larger free window, including a wrapped one.
      a = base_path(); b = a; a.bytes_out = 32'd100; b.bytes_out = 32'd3000;
      queue_pair(a, b);
   endtask

   // One pass built around a template path, with a steady exclusion most of the time.
   task automatic queue_random_pass(input idle_phase_type ph, inout int unsigned count);
      path_req_type tmpl;
      path_req_type p;
      int unsigned len;
      bit ex_valid;
      bit [3:0] ex_index;
      bit noisy;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 6);
      tmpl = random_path();
      ex_valid = $urandom_range(0, 1);
      ex_index = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, len - 1));
      noisy = $urandom_range(0, 9) == 0;
      for (int unsigned i = 0; i < len; i++) begin
         case ($urandom_range(0, 4))
            0:       p = random_path();
            1:       p = tmpl;
            default: p = mutate_path(tmpl);
         endcase
         if ($urandom_range(0, 2) == 0) tmpl = p;
         p.exclude_valid = noisy ? 1'($urandom) : ex_valid;
         p.exclude_index = noisy ? 4'($urandom) : ex_index;
         p.last = (i == len - 1);
         p.phase = ph;
         path_queue.push_back(p);
         count++;
      end
   endtask

   // Request driver: holds an offered request until it is taken.
   always @(posedge clock) begin : drive_requests
      path_req_type taken;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            taken = path_queue.pop_front();
            rank_path(taken);
            active_phase = taken.phase;
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (path_queue.size() != 0 &&
                $urandom_range(0, 99) >= idle_percent(path_queue[0].phase, 1'b0)) begin
               req_tdata <= pack_path(path_queue[0]);
               req_tlast <= path_queue[0].last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response receiver with random stalls and the long hold-off.
   always @(posedge clock) begin
      rsp_tready <= !hold_off && ($urandom_range(0, 99) >= idle_percent(active_phase, 1'b1));
   end

   // Response monitor: compares each result with the oldest expected index.
   always @(posedge clock) begin : check_responses
      bit [3:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (best_index_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response best_index=%0d", rsp_tdata[3:0]));
         end else begin
            want = best_index_q.pop_front();
            if (rsp_tdata[3:0] !== want) begin
               report_mismatch($sformatf("best_index got %0d, expected %0d",
                                         rsp_tdata[3:0], want));
            end
         end
      end
   end

   // Long receiver hold-off while requests keep coming, so the block backs up.
   initial begin
      @(posedge clock);
      while (accepted_count < HOLD_OFF_START) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Timeout watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stimulus, reset and end of run.
   initial begin
      int unsigned count;
      count = 0;
      pass_pos = 4'd0;
      best_pos = 4'd0;
      best_path = base_path();
      queue_directed();
      while (count < RANDOM_ITEMS) begin
         queue_random_pass(idle_phase_type'((count / PHASE_ITEMS) % 4), count);
      end
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (path_queue.size() != 0 || req_tvalid || best_index_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (best_index_q.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", best_index_q.size()));
      end
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
